@@ src/line_rasterizer_three_mode_unit_defines.svh @@
// Assertion macros used by the line rasterizer checker.
`ifndef LINE_RASTERIZER_THREE_MODE_UNIT_DEFINES_SVH
`define LINE_RASTERIZER_THREE_MODE_UNIT_DEFINES_SVH

// Consequent checked on the same edge as the antecedent.
`define LR3M_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line rasterizer check failed");

// Consequent checked on the edge that follows the antecedent.
`define LR3M_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line rasterizer check failed");

`endif

@@ src/lr3m_pkg.sv @@
// Shared types and constants of the line rasterizer.
package lr3m_pkg;

  localparam int COORD_BITS    = 12;
  localparam int COLOR_BITS    = 24;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = COLOR_BITS;

  localparam logic [COLOR_BITS-1:0] COLOR_RESET = COLOR_BITS'(255);

  localparam logic CMD_START = 1'b0;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLOR = CFG_IDX_BITS'(1);

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_DDA  = 2'd1,
    MODE_MID  = 2'd2,
    MODE_BRES = 2'd3
  } mode_t;

  typedef struct packed {
    logic                  cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } lr3m_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } lr3m_out_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic div_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;
    logic need_div;
  } dp_status_t;

endpackage

@@ src/lr3m_div.sv @@
// One lane of the restoring divider that forms a DDA increment.
module lr3m_div #(
  parameter int MAG_BITS = 12,
  parameter int QUO_BITS = 17
) (
  input  logic                clk,
  input  logic                load,
  input  logic                step,
  input  logic [MAG_BITS-1:0] mag,
  input  logic [MAG_BITS-1:0] divisor,
  output logic [QUO_BITS-1:0] quo
);

  logic [MAG_BITS:0]   rem;
  logic [QUO_BITS-1:0] q;
  logic                ge;
  logic [MAG_BITS:0]   diff;

  // mag <= divisor, so the first bit is the integer bit and rem stays below 2*divisor
  always_comb begin
    ge   = rem >= {1'b0, divisor};
    diff = ge ? (rem - {1'b0, divisor}) : rem;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= {1'b0, mag};
      q   <= '0;
    end else if (step) begin
      rem <= {diff[MAG_BITS-1:0], 1'b0};
      q   <= {q[QUO_BITS-2:0], ge};
    end
  end

  assign quo = q;

endmodule

@@ src/lr3m_ctrl.sv @@
// Controller of the line rasterizer: item slot, execute and divide sequencing.
module lr3m_ctrl #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lr3m_pkg::dp_status_t status,
  output lr3m_pkg::dp_cmd_t    cmd
);
  import lr3m_pkg::*;

  localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

  typedef enum logic [2:0] {
    S_EMPTY = 3'b001,
    S_FULL  = 3'b010,
    S_DIV   = 3'b100
  } state_t;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] count, count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_EMPTY: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_FULL;
        end
      end
      S_FULL: begin
        if (status.slot_free) begin
          cmd.exec = 1'b1;
          if (status.need_div) begin
            state_next = S_DIV;
            count_next = CNT_BITS'(FRAC_BITS);
          end else begin
            in_stall = 1'b0;
            if (in_valid) begin
              cmd.load_item = 1'b1;
            end else begin
              state_next = S_EMPTY;
            end
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (count == '0) begin
          state_next = S_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        state_next = S_EMPTY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_EMPTY;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

endmodule

@@ src/lr3m_dp.sv @@
// Datapath of the line rasterizer: config, line state, stepping and output register.
module lr3m_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [lr3m_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lr3m_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  lr3m_pkg::lr3m_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lr3m_pkg::lr3m_out_t                 out_data,
  input  lr3m_pkg::dp_cmd_t                   cmd,
  output lr3m_pkg::dp_status_t                status
);
  import lr3m_pkg::*;

  localparam int CB        = COORD_BITS;
  localparam int POS_BITS  = CB + FRAC_BITS + 1;
  localparam int QUO_BITS  = FRAC_BITS + 1;
  localparam int INC_BITS  = FRAC_BITS + 2;
  localparam int DEC_BITS  = CB + 5;
  localparam int DSUM_BITS = DEC_BITS + 1;
  localparam logic [POS_BITS-1:0] HALF = POS_BITS'(1) << (FRAC_BITS - 1);

  function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // round half up, clamp to the coordinate range
  function automatic logic [CB-1:0] fix_round(input logic [POS_BITS-1:0] pos);
    logic [POS_BITS-1:0] sum;
    logic [CB:0]         r;
    sum = {1'b0, pos[POS_BITS-2:0]} + HALF;
    r   = sum[POS_BITS-1:FRAC_BITS];
    if (pos[POS_BITS-1]) return '0;
    else if (r[CB]) return '1;
    else return r[CB-1:0];
  endfunction

  // config
  mode_t                 mode;
  logic [COLOR_BITS-1:0] pixel_color;

  // line state
  lr3m_in_t                    item;
  logic                        line_active, line_active_next;
  logic [CB-1:0]               steps_left;
  logic [CB-1:0]               cur_x, cur_y;
  logic signed [DEC_BITS-1:0]  decision;
  logic signed [CB:0]          delta_x, delta_y;
  logic [POS_BITS-1:0]         fix_pos_x, fix_pos_y;
  logic [CB-1:0]               div_steps;
  logic [QUO_BITS-1:0]         quo_x, quo_y;
  logic                        out_valid_next;

  // start-item decode
  logic                        is_start;
  logic signed [CB:0]          dx_s, dy_s, adx_w, ady_w;
  logic [CB-1:0]               adx, ady, steps, start_steps;
  logic signed [CB+2:0]        dec0, dec_init;
  logic                        div_load;

  // advance
  logic                        run_adv, produce;
  logic signed [INC_BITS-1:0]  inc_x, inc_y;
  logic [POS_BITS-1:0]         pos_x_n, pos_y_n;
  logic signed [CB+1:0]        dxdy;
  logic signed [DSUM_BITS-1:0] dec_w, two_dy, two_dxdy, opnd, dec_sum;
  logic signed [DEC_BITS-1:0]  dec_sat;
  logic                        neg, use_a, y_step;
  logic [CB-1:0]               adv_x, adv_y, new_x, new_y, new_steps;
  lr3m_out_t                   res;

  always_comb begin
    is_start = (item.cmd == CMD_START);
    dx_s  = $signed({1'b0, item.x_end}) - $signed({1'b0, item.x_start});
    dy_s  = $signed({1'b0, item.y_end}) - $signed({1'b0, item.y_start});
    adx_w = dx_s[CB] ? -dx_s : dx_s;
    ady_w = dy_s[CB] ? -dy_s : dy_s;
    adx   = adx_w[CB-1:0];
    ady   = ady_w[CB-1:0];
    steps = (adx > ady) ? adx : ady;
    if (mode == MODE_DDA) begin
      start_steps = steps;
    end else begin
      start_steps = dx_s[CB] ? '0 : dx_s[CB-1:0];
    end
    dec0     = $signed({dy_s[CB], dy_s, 1'b0}) - $signed({{2{dx_s[CB]}}, dx_s});
    dec_init = (mode == MODE_MID) ? -dec0 : dec0;
    div_load = cmd.exec && is_start && (mode != MODE_NONE);

    status.slot_free = !out_valid || !out_stall;
    status.need_div  = is_start && (mode != MODE_NONE) && (steps != '0);
  end

  // DDA increments come straight from the divider quotients
  always_comb begin
    inc_x   = delta_x[CB] ? -$signed({1'b0, quo_x}) : $signed({1'b0, quo_x});
    inc_y   = delta_y[CB] ? -$signed({1'b0, quo_y}) : $signed({1'b0, quo_y});
    pos_x_n = fix_pos_x + {{(POS_BITS-INC_BITS){inc_x[INC_BITS-1]}}, inc_x};
    pos_y_n = fix_pos_y + {{(POS_BITS-INC_BITS){inc_y[INC_BITS-1]}}, inc_y};
  end

  // midpoint / Bresenham decision: non-negative always subtracts
  always_comb begin
    neg      = decision[DEC_BITS-1];
    dxdy     = $signed({delta_x[CB], delta_x}) - $signed({delta_y[CB], delta_y});
    dec_w    = {decision[DEC_BITS-1], decision};
    two_dy   = {{4{delta_y[CB]}}, delta_y, 1'b0};
    two_dxdy = {{3{dxdy[CB+1]}}, dxdy, 1'b0};
    use_a    = (mode == MODE_MID) ? !neg : neg;
    y_step   = (mode == MODE_MID) ? neg : !neg;
    opnd     = use_a ? two_dy : two_dxdy;
    dec_sum  = neg ? (dec_w + opnd) : (dec_w - opnd);
    if (dec_sum[DSUM_BITS-1] != dec_sum[DSUM_BITS-2]) begin
      dec_sat = dec_sum[DSUM_BITS-1] ? {1'b1, {(DEC_BITS-1){1'b0}}}
                                     : {1'b0, {(DEC_BITS-1){1'b1}}};
    end else begin
      dec_sat = dec_sum[DEC_BITS-1:0];
    end
  end

  always_comb begin
    run_adv = !is_start && line_active && (mode != MODE_NONE);
    produce = cmd.exec && (is_start ? (mode != MODE_NONE) : run_adv);
    if (mode == MODE_DDA) begin
      adv_x = fix_round(pos_x_n);
      adv_y = fix_round(pos_y_n);
    end else begin
      adv_x = sat_inc(cur_x);
      adv_y = y_step ? sat_inc(cur_y) : cur_y;
    end
    new_x     = is_start ? item.x_start : adv_x;
    new_y     = is_start ? item.y_start : adv_y;
    new_steps = is_start ? start_steps : steps_left - 1'b1;

    res.pixel_x = new_x;
    res.pixel_y = new_y;
    res.color   = pixel_color;
    res.last    = (new_steps == '0);

    line_active_next = line_active;
    if (cmd.exec && is_start) begin
      line_active_next = (mode != MODE_NONE) && (start_steps != '0);
    end else if (cmd.exec && run_adv) begin
      line_active_next = (new_steps != '0);
    end

    out_valid_next = out_valid;
    if (produce) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_NONE;
      pixel_color <= COLOR_RESET;
      line_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_MODE:  mode <= mode_t'(cfg_data[1:0]);
          CFG_COLOR: pixel_color <= cfg_data[COLOR_BITS-1:0];
          default: ;
        endcase
      end
      line_active <= line_active_next;
      out_valid   <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.exec && is_start && (mode == MODE_NONE)) begin
      steps_left <= '0;
    end
    if (div_load) begin
      delta_x   <= dx_s;
      delta_y   <= dy_s;
      fix_pos_x <= {1'b0, item.x_start, {FRAC_BITS{1'b0}}};
      fix_pos_y <= {1'b0, item.y_start, {FRAC_BITS{1'b0}}};
      decision  <= {{2{dec_init[CB+2]}}, dec_init};
      div_steps <= steps;
    end else if (produce) begin
      if (mode == MODE_DDA) begin
        fix_pos_x <= pos_x_n;
        fix_pos_y <= pos_y_n;
      end else begin
        decision <= dec_sat;
      end
    end
    if (produce) begin
      steps_left <= new_steps;
      cur_x      <= new_x;
      cur_y      <= new_y;
      out_data   <= res;
    end
  end

  lr3m_div #(
    .MAG_BITS (CB),
    .QUO_BITS (QUO_BITS)
  ) u_div_x (
    .clk     (clk),
    .load    (div_load),
    .step    (cmd.div_step),
    .mag     (adx),
    .divisor (div_steps),
    .quo     (quo_x)
  );

  lr3m_div #(
    .MAG_BITS (CB),
    .QUO_BITS (QUO_BITS)
  ) u_div_y (
    .clk     (clk),
    .load    (div_load),
    .step    (cmd.div_step),
    .mag     (ady),
    .divisor (div_steps),
    .quo     (quo_y)
  );

endmodule

@@ src/line_rasterizer_three_mode_unit.sv @@
// Line rasterizer top level: controller, datapath and DDA divider.
//
// Draws one line per start request and one pixel per advance request, in DDA
// (mode 1, all octants, Q.FRAC_BITS fixed point, round half up), midpoint
// (mode 2, x-major first octant) or Bresenham (mode 3, x-major first octant)
// form; mode 0 draws nothing. A request is taken into a one-entry item
// register and executed once the output register is free; its pixel then
// sits in the output register until taken, and the next request is accepted
// meanwhile. Advance requests stream at one per cycle as long as the output
// is drained. A start request in modes 1 to 3 also loads two restoring
// dividers (x and y increments); if its line is not a single point they
// produce one quotient bit per cycle, and input is stalled while they run
// after the start executes; that divider loop sets the cost of a start. The
// last flag marks the final pixel; pixel coordinates saturate at the
// coordinate maximum. Config writes (mode at index 0, color at index 1)
// must happen only while no request is in flight.
module line_rasterizer_three_mode_unit #(
  parameter int FRAC_BITS = lr3m_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [lr3m_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [lr3m_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  lr3m_pkg::lr3m_in_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output lr3m_pkg::lr3m_out_t                out_data
);
  import lr3m_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // sequencing: item slot, execute, divide
  lr3m_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (dp_status),
    .cmd      (dp_cmd)
  );

  // line state, stepping arithmetic, config and output register
  lr3m_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (dp_cmd),
    .status    (dp_status)
  );

endmodule

@@ src/lr3m_checker.sv @@
// Port-level checks of the line rasterizer and their bind.
`include "line_rasterizer_three_mode_unit_defines.svh"

module lr3m_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input lr3m_pkg::lr3m_out_t out_data
);

  // a held pixel neither drops nor changes
  `LR3M_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // a fresh pixel follows an accepted request through the item and output registers
  `LR3M_ASSERT_SAME(a_out_cause, $rose(out_valid), $past(in_valid && !in_stall, 2))
  // ready for a request right out of reset
  `LR3M_ASSERT_SAME(a_ready_after_rst, $fell(rst), !in_stall)

endmodule

bind line_rasterizer_three_mode_unit lr3m_checker u_lr3m_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
